// File: rtl/core/arpe_pkg.sv
// ----------------------------------------------------------------------------
// arpe_pkg
// Shared types for the audio RMS / peak envelope block.
// ----------------------------------------------------------------------------
package arpe_pkg;

  // one input beat: a PCM16 frame plus the buffer length
  typedef struct packed {
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
    logic signed [15:0] sample_4;
    logic signed [15:0] sample_5;
    logic signed [15:0] sample_6;
    logic signed [15:0] sample_7;
    logic [12:0]        buffer_length;
  } frame_t;

  // one output beat: a closed bin
  typedef struct packed {
    logic [3:0]  bin_number;
    logic [14:0] rms_level;
    logic [14:0] peak_level;
    logic        final_bin;
  } result_t;

  localparam logic [3:0]  CHAN_RESET = 4'd2;
  localparam logic [14:0] Q15_MAX    = 15'h7fff;
  localparam logic [3:0]  SQRT_TOP   = 4'd14;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_PREP2,
    ST_QSTART,
    ST_QDIV,
    ST_SQRT,
    ST_PSTART,
    ST_PDIV,
    ST_EMIT
  } back_state_t;

endpackage

// File: rtl/core/arpe_div.sv
// ----------------------------------------------------------------------------
// arpe_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arpe_div #(
  parameter int NUMW = 51,
  parameter int DENW = 25
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quo
);
  localparam int CNTW = $clog2(NUMW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] den_r;
  logic [DENW:0]   sh;
  logic            fit;

  // trial subtract of the shifted remainder
  assign sh  = {rem, quo[NUMW-1]};
  assign fit = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNTW'(NUMW);
        quo   <= num;
        rem   <= '0;
        den_r <= den;
      end else if (busy) begin
        rem <= fit ? DENW'(sh - {1'b0, den_r}) : DENW'(sh);
        quo <= {quo[NUMW-2:0], fit};
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/core/arpe_front.sv
// ----------------------------------------------------------------------------
// arpe_front
// Mixes the active channels of a frame to a mono magnitude, clamps the length.
// ----------------------------------------------------------------------------
module arpe_front #(
  parameter int FRAME_LIMIT  = 4096,
  parameter int MAX_CHANNELS = 8,
  localparam int MW = 16 + $clog2(MAX_CHANNELS),
  localparam int NW = $clog2(FRAME_LIMIT + 1)
) (
  input  arpe_pkg::frame_t in_data,
  input  logic [3:0]       chan,
  output logic [MW-1:0]    mag,
  output logic [NW-1:0]    len
);
  import arpe_pkg::*;

  logic signed [15:0] smp [8];
  logic signed [MW:0] sum;
  logic [3:0]         cc;

  assign smp[0] = in_data.sample_0;
  assign smp[1] = in_data.sample_1;
  assign smp[2] = in_data.sample_2;
  assign smp[3] = in_data.sample_3;
  assign smp[4] = in_data.sample_4;
  assign smp[5] = in_data.sample_5;
  assign smp[6] = in_data.sample_6;
  assign smp[7] = in_data.sample_7;

  // effective channel count
  always_comb begin
    if (chan == 4'd0) begin
      cc = 4'd1;
    end else if (32'(chan) > MAX_CHANNELS) begin
      cc = 4'(MAX_CHANNELS);
    end else begin
      cc = chan;
    end
  end

  // mono sum and its magnitude
  always_comb begin
    sum = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (4'(i) < cc) begin
        sum = sum + (MW + 1)'(smp[i]);
      end
    end
    mag = sum[MW] ? MW'(-sum) : MW'(sum);
  end

  // clamped buffer length
  always_comb begin
    if (in_data.buffer_length == 13'd0) begin
      len = NW'(1);
    end else if (32'(in_data.buffer_length) > FRAME_LIMIT) begin
      len = NW'(FRAME_LIMIT);
    end else begin
      len = NW'(in_data.buffer_length);
    end
  end
endmodule

// File: rtl/core/arpe_fifo.sv
// ----------------------------------------------------------------------------
// arpe_fifo
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module arpe_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [CW-1:0]    cnt;

  assign full  = cnt == CW'(DEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (32'(wp) == DEPTH - 1) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (32'(rp) == DEPTH - 1) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

// File: rtl/core/arpe_back.sv
// ----------------------------------------------------------------------------
// arpe_back
// Bin bookkeeping, accumulation and the RMS / peak result sequencer.
// ----------------------------------------------------------------------------
module arpe_back #(
  parameter int BINS         = 16,
  parameter int FRAME_LIMIT  = 4096,
  parameter int MAX_CHANNELS = 8,
  localparam int MW = 16 + $clog2(MAX_CHANNELS),
  localparam int NW = $clog2(FRAME_LIMIT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [3:0]        chan,
  input  logic              q_valid,
  input  logic [MW-1:0]     q_mag,
  input  logic [NW-1:0]     q_len,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output arpe_pkg::result_t out_data
);
  import arpe_pkg::*;

  localparam int CW  = $clog2(MAX_CHANNELS + 1);
  localparam int PW  = $clog2(FRAME_LIMIT);
  localparam int NBW = $clog2(BINS + 1);
  localparam int SW  = 2 * MW + NW;
  localparam int DW  = 2 * CW + NW;
  localparam int XW  = SW + 30;
  localparam int PNW = MW + 15;

  back_state_t state, state_next;

  logic [PW-1:0]  pos;
  logic [NBW-1:0] next_bin;
  logic [SW-1:0]  sacc;
  logic [MW-1:0]  peak;
  logic [NW-1:0]  kcnt;
  logic           phase;
  logic [MW-1:0]  cur_mag;
  logic [NW-1:0]  cur_len;
  logic [PW-1:0]  cur_p;
  logic [XW-1:0]  x;
  logic [DW-1:0]  dden;
  logic [SW-1:0]  qv;
  logic [14:0]    r;
  logic [3:0]     bit_i;
  logic [14:0]    rms_r;
  logic [14:0]    pk_r;

  logic [CW-1:0]  cc;
  logic [31:0]    lhs, rhs, pmin;
  logic           close, end_buf;
  logic [14:0]    t;
  logic [29:0]    tt;
  logic [PNW-1:0] pn;
  logic           div_start, div_done;
  logic [SW-1:0]  div_num, div_quo;
  logic [DW-1:0]  div_den;

  // effective channel count
  always_comb begin
    if (chan == 4'd0) begin
      cc = CW'(1);
    end else if (32'(chan) > MAX_CHANNELS) begin
      cc = CW'(MAX_CHANNELS);
    end else begin
      cc = CW'(chan);
    end
  end

  // bin end test: floor(n*(b+1)/BINS) <= p+phase  <=>  n*(b+1) < (p+phase+1)*BINS
  assign lhs     = 32'(cur_len) * (32'(next_bin) + 32'd1);
  assign rhs     = (32'(cur_p) + 32'd1 + 32'(phase)) * BINS;
  assign close   = (32'(next_bin) < BINS) && (lhs < rhs);
  assign end_buf = (32'(cur_p) + 32'd1) >= 32'(cur_len);
  assign pmin    = (32'(pos) > 32'(q_len) - 32'd1) ? 32'(q_len) - 32'd1 : 32'(pos);

  // square root trial and peak numerator
  assign t  = r | (15'd1 << bit_i);
  assign tt = 30'(t) * 30'(t);
  assign pn = ((PNW'(peak) << 15) - PNW'(peak)) >> 15;

  arpe_div #(.NUMW(SW), .DENW(DW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (q_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (close) begin
          state_next = ST_PREP;
        end else if (phase) begin
          state_next = ST_IDLE;
        end
      end
      ST_PREP:   state_next = (kcnt == '0) ? ST_EMIT : ST_PREP2;
      ST_PREP2:  state_next = ST_QSTART;
      ST_QSTART: state_next = ST_QDIV;
      ST_QDIV:   if (div_done) state_next = ST_SQRT;
      ST_SQRT:   if (bit_i == 4'd0) state_next = ST_PSTART;
      ST_PSTART: state_next = ST_PDIV;
      ST_PDIV:   if (div_done) state_next = ST_EMIT;
      ST_EMIT:   if (!out_valid || !out_stall) state_next = ST_CHECK;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      ST_IDLE:   q_pop = q_valid;
      ST_QSTART: begin
        div_start = 1'b1;
        div_num   = SW'(x >> 30);
        div_den   = dden;
      end
      ST_PSTART: begin
        div_start = 1'b1;
        div_num   = SW'(pn);
        div_den   = DW'(cc);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // bin state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      next_bin  <= '0;
      sacc      <= '0;
      peak      <= '0;
      kcnt      <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a taken beat drops valid unless the emit state refills it
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur_mag <= q_mag;
            cur_len <= q_len;
            cur_p   <= PW'(pmin);
            phase   <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (!close && !phase) begin
            // add this frame to the open bin
            if (32'(next_bin) < BINS) begin
              sacc <= sacc + SW'((2 * MW)'(cur_mag) * (2 * MW)'(cur_mag));
              if (cur_mag > peak) begin
                peak <= cur_mag;
              end
              kcnt <= kcnt + 1'b1;
            end
            phase <= 1'b1;
          end else if (!close) begin
            // advance the frame position
            if (end_buf) begin
              pos      <= '0;
              next_bin <= '0;
              sacc     <= '0;
              peak     <= '0;
              kcnt     <= '0;
            end else begin
              pos <= cur_p + 1'b1;
            end
          end
        end
        ST_PREP: begin
          // 32767^2 = 2^30 - 2^16 + 1
          x     <= (XW'(sacc) << 30) + XW'(sacc);
          dden  <= DW'((2 * CW)'(cc) * (2 * CW)'(cc) * DW'(kcnt));
          rms_r <= '0;
          pk_r  <= '0;
        end
        ST_PREP2: x <= x - (XW'(sacc) << 16);
        ST_QDIV: begin
          if (div_done) begin
            qv    <= div_quo;
            r     <= '0;
            bit_i <= SQRT_TOP;
          end
        end
        ST_SQRT: begin
          if (XW'(tt) <= XW'(qv)) begin
            r <= t;
          end
          if (bit_i == 4'd0) begin
            rms_r <= (XW'(tt) <= XW'(qv)) ? t : r;
          end else begin
            bit_i <= bit_i - 1'b1;
          end
        end
        ST_PDIV: begin
          if (div_done) begin
            pk_r <= (div_quo > SW'(Q15_MAX)) ? Q15_MAX : 15'(div_quo);
          end
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid           <= 1'b1;
            out_data.bin_number <= 4'(next_bin);
            out_data.rms_level  <= rms_r;
            out_data.peak_level <= pk_r;
            out_data.final_bin  <= 32'(next_bin) == BINS - 1;
            sacc                <= '0;
            peak                <= '0;
            kcnt                <= '0;
            next_bin            <= next_bin + 1'b1;
          end
        end
        default: begin
          phase <= phase;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    32'(next_bin) <= BINS)
    else $error("next_bin past the last bin");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE)
    else $error("queue popped while busy");
  a_sqrt_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT |-> kcnt != '0)
    else $error("root taken of an empty bin");
`endif
endmodule

// File: rtl/core/audio_rms_peak_envelope.sv
// ----------------------------------------------------------------------------
// audio_rms_peak_envelope
// Mono RMS and peak per bin over buffers of PCM16 frames.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  frame_t  (8 samples, buffer_length)
//   out      out  out_valid/out_stall result_t (bin, rms, peak, final)
//   cfg      in   cfg_valid/cfg_ready cfg_data (channel_count)
//
// Each frame is taken by the back sequencer, which for each bin that it closes
// runs the serial divider (one bit per cycle) for the RMS quotient and the peak
// scale and the 15-step root, both skipped for an empty bin; a stalled out beat
// holds the sequencer in its emit state.
// Reset is synchronous; channel_count returns to 2 and all bins clear.
// A four-beat queue lets frames arrive while the back works or out stalls.
// ----------------------------------------------------------------------------
module audio_rms_peak_envelope #(
  parameter int BINS         = 16,
  parameter int FRAME_LIMIT  = 4096,
  parameter int MAX_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  arpe_pkg::frame_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output arpe_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);
  import arpe_pkg::*;

  localparam int MW = 16 + $clog2(MAX_CHANNELS);
  localparam int NW = $clog2(FRAME_LIMIT + 1);

  logic [3:0]       chan;
  logic [MW-1:0]    f_mag, q_mag;
  logic [NW-1:0]    f_len, q_len;
  logic             q_full, q_empty, q_pop, q_push;

  // channel count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      chan <= CHAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      chan <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  arpe_front #(.FRAME_LIMIT(FRAME_LIMIT), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .in_data(in_data),
    .chan   (chan),
    .mag    (f_mag),
    .len    (f_len)
  );

  arpe_fifo #(.WIDTH(MW + NW), .DEPTH(4)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata({f_mag, f_len}),
    .pop  (q_pop),
    .rdata({q_mag, q_len}),
    .full (q_full),
    .empty(q_empty)
  );

  arpe_back #(
    .BINS        (BINS),
    .FRAME_LIMIT (FRAME_LIMIT),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .chan     (chan),
    .q_valid  (!q_empty),
    .q_mag    (q_mag),
    .q_len    (q_len),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );
endmodule

// File: sim/envelope_checker.sv
// ----------------------------------------------------------------------------
// envelope_checker
// Watches the frame, bin and config channels of the envelope block, predicts
// every closed bin from the accepted frames and compares field by field.
// ----------------------------------------------------------------------------
module envelope_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  arpe_pkg::frame_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  arpe_pkg::result_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [3:0]        cfg_data,
  output int                errors,
  output int                pending,
  output int                bins_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import arpe_pkg::*;

  localparam int NBINS  = 16;
  localparam int NMAX   = 4096;
  localparam int CHMAX  = 8;

  // predictor state
  logic [3:0]  chan_reg;
  int unsigned frame_pos;
  int unsigned bin_next;
  longint unsigned sq_acc;
  int unsigned pk_mag;
  int unsigned bin_frames;
  result_t     bin_queue[$];

  assign pending = bin_queue.size();

  function automatic int unsigned bin_edge(int unsigned n, int unsigned b);
    return (n * b) / NBINS;
  endfunction

  // floor of 32767*sqrt(s/k)/(32768*c) by bisection on r
  function automatic int unsigned rms_q15(longint unsigned s, int unsigned k,
                                          int unsigned c);
    logic [127:0] lhs, rhs;
    int unsigned lo, hi, mid;
    lo = 0;
    hi = 32767;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 128'(mid * c) * 128'(mid * c) * 128'(k) << 30;
      rhs = 128'(32767 * 32767) * 128'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void close_bin(int unsigned c);
    result_t r;
    longint unsigned pk;
    r = '0;
    if (bin_frames != 0) begin
      r.rms_level = 15'(rms_q15(sq_acc, bin_frames, c));
      pk = (64'd32767 * pk_mag) / (64'd32768 * c);
      r.peak_level = (pk > 32767) ? Q15_MAX : 15'(pk);
    end
    r.bin_number = 4'(bin_next);
    r.final_bin = (bin_next == NBINS - 1);
    bin_queue = {bin_queue, r};
    sq_acc = 0;
    pk_mag = 0;
    bin_frames = 0;
    bin_next++;
  endfunction

  function automatic void take_frame(frame_t f);
    int unsigned c, n, p, mag;
    int sum;
    logic signed [15:0] s[8];
    c = 32'(chan_reg);
    n = 32'(f.buffer_length);
    if (c == 0) c = 1;
    if (c > CHMAX) c = CHMAX;
    if (n == 0) n = 1;
    if (n > NMAX) n = NMAX;
    p = frame_pos;
    if (p > n - 1) p = n - 1;
    s = '{f.sample_0, f.sample_1, f.sample_2, f.sample_3,
          f.sample_4, f.sample_5, f.sample_6, f.sample_7};
    sum = 0;
    for (int i = 0; i < c; i++) sum += int'(s[i]);
    mag = (sum < 0) ? -sum : sum;
    while (bin_next < NBINS && bin_edge(n, bin_next + 1) <= p) close_bin(c);
    if (bin_next < NBINS) begin
      sq_acc += longint'(mag) * mag;
      if (mag > pk_mag) pk_mag = mag;
      bin_frames++;
    end
    while (bin_next < NBINS && bin_edge(n, bin_next + 1) <= p + 1) close_bin(c);
    if (p + 1 >= n) begin
      frame_pos = 0;
      bin_next = 0;
      sq_acc = 0;
      pk_mag = 0;
      bin_frames = 0;
    end else begin
      frame_pos = p + 1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      chan_reg = CHAN_RESET;
      frame_pos = 0;
      bin_next = 0;
      sq_acc = 0;
      pk_mag = 0;
      bin_frames = 0;
      bin_queue.delete();
      errors = 0;
      bins_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) chan_reg = cfg_data;
      if (in_valid && !in_stall) take_frame(in_data);
      if (out_valid && !out_stall) begin
        bins_seen++;
        if (bin_queue.size() == 0) begin
          report_mismatch("unexpected bin beat", int'(out_data.bin_number), -1);
        end else begin
          want = bin_queue.pop_front();
          if (out_data.bin_number != want.bin_number)
            report_mismatch("bin_number", int'(out_data.bin_number),
                            int'(want.bin_number));
          if (out_data.rms_level != want.rms_level)
            report_mismatch("rms_level", int'(out_data.rms_level),
                            int'(want.rms_level));
          if (out_data.peak_level != want.peak_level)
            report_mismatch("peak_level", int'(out_data.peak_level),
                            int'(want.peak_level));
          if (out_data.final_bin != want.final_bin)
            report_mismatch("final_bin", int'(out_data.final_bin),
                            int'(want.final_bin));
        end
      end
    end
  end
endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives frames and channel-count writes into the envelope block with random
// gaps and output stalls; the checker predicts and compares every bin beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import arpe_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  frame_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  result_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  int errors, pending, bins_seen;
  int cycles = 0;
  int frames_sent = 0;
  bit calm = 0;       // no idling in the last part
  bit hold_out = 0;   // long receiver hold-off
  bit done = 0;

  always #4 clk = ~clk;

  audio_rms_peak_envelope u_top (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  envelope_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data,
    .errors, .pending, .bins_seen
  );

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    int len;
    @(posedge clk);
    while (!done) begin
      if (hold_out) begin
        out_stall <= 1;
        repeat (400) @(posedge clk);
        hold_out = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 19);
        out_stall <= 1;
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(signed'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  // send one frame and wait for its acceptance
  task automatic send_frame(logic [12:0] len, bit rnd, logic signed [15:0] fill);
    frame_t f;
    if (rnd) begin
      f = {pick_sample(), pick_sample(), pick_sample(), pick_sample(),
           pick_sample(), pick_sample(), pick_sample(), pick_sample(), len};
    end else begin
      f = {fill, fill, fill, fill, fill, fill, fill, fill, len};
    end
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 0;
    @(posedge clk);
  endtask

  // wait until all bins are out, then let the back settle
  task automatic drain();
    drop_valid();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_channels(logic [3:0] value);
    drain();
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // a whole buffer of random frames
  task automatic send_buffer(int len);
    for (int i = 0; i < len; i++) send_frame(13'(len), 1'b1, '0);
  endtask

  initial begin
    logic [12:0] len;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset channel count, extremes, short buffers
    send_buffer(1);
    for (int i = 0; i < 4; i++) send_frame(13'd4, 1'b0, 16'sh7fff);
    for (int i = 0; i < 4; i++) send_frame(13'd4, 1'b0, 16'sh8000);
    write_channels(4'd8);
    for (int i = 0; i < 3; i++) send_frame(13'd3, 1'b0, 16'sh8000);
    send_frame(13'd0, 1'b0, 16'sh7fff);       // zero length
    write_channels(4'd0);                     // zero channels
    send_frame(13'd5, 1'b1, '0);
    send_frame(13'd2, 1'b1, '0);              // length shrinks mid-buffer
    send_frame(13'h1fff, 1'b1, '0);           // length above the maximum
    write_channels(4'd15);                    // above the maximum
    send_buffer(2);
    send_frame(13'd17, 1'b0, 16'sh0000);

    // receiver holds off while frames keep coming
    write_channels(4'd1);
    hold_out = 1;
    send_buffer(20);
    drain();

    // random phase
    while (frames_sent < 360) begin
      if (frames_sent > 300) calm = 1;
      if (!calm && $urandom_range(0, 3) == 0) write_channels(4'($urandom));
      case ($urandom_range(0, 9))
        0: len = 13'($urandom);                      // noise lengths
        1: len = 13'($urandom_range(40, 64));
        default: len = 13'($urandom_range(1, 24));
      endcase
      if (len != 0 && len <= 64 && $urandom_range(0, 7) != 0) send_buffer(int'(len));
      else send_frame(len, 1'b1, '0);
    end
    write_channels(4'd3);
    // a few frames of the largest buffer
    for (int i = 0; i < 4; i++) send_frame(13'd4096, 1'b0, 16'sh7fff);

    drop_valid();
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    done = 1;
    $display("covered %0d frames and %0d bin beats over several channel counts,",
             frames_sent, bins_seen);
    $display("buffer lengths from 1 past the maximum, with stalls and gaps");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
